// ===== hw/rtl/cpu_8bit_alu_with_flags_top_assert.svh =====
// -----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags_top_assert.svh
// Assertion macros for the 8-bit ALU; they expand to nothing in synthesis.
// -----------------------------------------------------------------------------
`ifndef CPU_8BIT_ALU_WITH_FLAGS_TOP_ASSERT_SVH
`define CPU_8BIT_ALU_WITH_FLAGS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define CPU8ALU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

`define CPU8ALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`else

`define CPU8ALU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define CPU8ALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/cpu8alu_pkg.sv =====
// -----------------------------------------------------------------------------
// cpu8alu_pkg
// Operation codes, constants and the result type of the 8-bit ALU.
// -----------------------------------------------------------------------------
`default_nettype none

package cpu8alu_pkg;

	localparam int unsigned KindW = 5;
	localparam int unsigned DataW = 8;

	localparam logic [KindW-1:0] OP_ADD  = 5'd0;
	localparam logic [KindW-1:0] OP_ADC  = 5'd1;
	localparam logic [KindW-1:0] OP_SUB  = 5'd2;
	localparam logic [KindW-1:0] OP_SBC  = 5'd3;
	localparam logic [KindW-1:0] OP_AND  = 5'd4;
	localparam logic [KindW-1:0] OP_XOR  = 5'd5;
	localparam logic [KindW-1:0] OP_OR   = 5'd6;
	localparam logic [KindW-1:0] OP_CP   = 5'd7;
	localparam logic [KindW-1:0] OP_INC  = 5'd8;
	localparam logic [KindW-1:0] OP_DEC  = 5'd9;
	localparam logic [KindW-1:0] OP_RLCA = 5'd10;
	localparam logic [KindW-1:0] OP_RRCA = 5'd11;
	localparam logic [KindW-1:0] OP_RLA  = 5'd12;
	localparam logic [KindW-1:0] OP_RRA  = 5'd13;
	localparam logic [KindW-1:0] OP_DAA  = 5'd14;
	localparam logic [KindW-1:0] OP_CPL  = 5'd15;
	localparam logic [KindW-1:0] OP_SCF  = 5'd16;
	localparam logic [KindW-1:0] OP_CCF  = 5'd17;

	localparam logic [DataW-1:0] DAA_LO_ADJ = 8'h06;
	localparam logic [DataW-1:0] DAA_HI_ADJ = 8'h60;
	localparam logic [DataW-1:0] DAA_HI_MAX = 8'h99;
	localparam logic [3:0]       BCD_MAX    = 4'd9;
	localparam logic [3:0]       NIB_MAX    = 4'hF;

	typedef struct packed {
		logic [DataW-1:0] value;
		logic             do_write;
		logic             zero;
		logic             sub;
		logic             half;
		logic             carry;
	} alu_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cpu8alu_core.sv =====
// -----------------------------------------------------------------------------
// cpu8alu_core
// Combinational datapath: computes the result byte and flags of one item.
// -----------------------------------------------------------------------------
`default_nettype none

module cpu8alu_core (
	input  wire logic [cpu8alu_pkg::KindW-1:0] kind,
	input  wire logic [cpu8alu_pkg::DataW-1:0] acc,
	input  wire logic [cpu8alu_pkg::DataW-1:0] operand,
	input  wire logic                          zero_in,
	input  wire logic                          sub_in,
	input  wire logic                          half_in,
	input  wire logic                          carry_in,
	output cpu8alu_pkg::alu_res_t              res
);

	logic                           cin;
	logic [cpu8alu_pkg::DataW:0]    sum9;
	logic [cpu8alu_pkg::DataW:0]    diff9;
	logic [4:0]                     hsum5;
	logic [4:0]                     hdiff5;
	logic [cpu8alu_pkg::DataW-1:0]  r;
	logic [cpu8alu_pkg::DataW-1:0]  adj;
	logic                           daa_c;

	always_comb begin
		cin    = ((kind == cpu8alu_pkg::OP_ADC) || (kind == cpu8alu_pkg::OP_SBC)) & carry_in;
		sum9   = {1'b0, acc} + {1'b0, operand} + {8'b0, cin};
		diff9  = {1'b0, acc} - {1'b0, operand} - {8'b0, cin};
		hsum5  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'b0, cin};
		hdiff5 = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'b0, cin};

		adj   = '0;
		daa_c = carry_in;
		if (!sub_in) begin
			if (carry_in || (acc > cpu8alu_pkg::DAA_HI_MAX)) begin
				adj   = adj | cpu8alu_pkg::DAA_HI_ADJ;
				daa_c = 1'b1;
			end
			if (half_in || (acc[3:0] > cpu8alu_pkg::BCD_MAX)) begin
				adj = adj | cpu8alu_pkg::DAA_LO_ADJ;
			end
		end else begin
			if (carry_in) begin
				adj = adj | cpu8alu_pkg::DAA_HI_ADJ;
			end
			if (half_in) begin
				adj = adj | cpu8alu_pkg::DAA_LO_ADJ;
			end
		end

		r   = '0;
		res = '{value: acc, do_write: 1'b0, zero: zero_in, sub: sub_in,
			half: half_in, carry: carry_in};

		unique case (kind) inside
			cpu8alu_pkg::OP_ADD, cpu8alu_pkg::OP_ADC: begin
				r   = sum9[7:0];
				res = '{value: r, do_write: 1'b1, zero: (r == '0), sub: 1'b0,
					half: hsum5[4], carry: sum9[8]};
			end
			cpu8alu_pkg::OP_SUB, cpu8alu_pkg::OP_SBC: begin
				r   = diff9[7:0];
				res = '{value: r, do_write: 1'b1, zero: (r == '0), sub: 1'b1,
					half: hdiff5[4], carry: diff9[8]};
			end
			cpu8alu_pkg::OP_CP: begin
				r   = diff9[7:0];
				res = '{value: acc, do_write: 1'b0, zero: (r == '0), sub: 1'b1,
					half: hdiff5[4], carry: diff9[8]};
			end
			cpu8alu_pkg::OP_AND: begin
				r   = acc & operand;
				res = '{value: r, do_write: 1'b1, zero: (r == '0), sub: 1'b0,
					half: 1'b1, carry: 1'b0};
			end
			cpu8alu_pkg::OP_XOR: begin
				r   = acc ^ operand;
				res = '{value: r, do_write: 1'b1, zero: (r == '0), sub: 1'b0,
					half: 1'b0, carry: 1'b0};
			end
			cpu8alu_pkg::OP_OR: begin
				r   = acc | operand;
				res = '{value: r, do_write: 1'b1, zero: (r == '0), sub: 1'b0,
					half: 1'b0, carry: 1'b0};
			end
			cpu8alu_pkg::OP_INC: begin
				r   = operand + 8'd1;
				res = '{value: r, do_write: 1'b1, zero: (r == '0), sub: 1'b0,
					half: (operand[3:0] == cpu8alu_pkg::NIB_MAX), carry: carry_in};
			end
			cpu8alu_pkg::OP_DEC: begin
				r   = operand - 8'd1;
				res = '{value: r, do_write: 1'b1, zero: (r == '0), sub: 1'b1,
					half: (operand[3:0] == 4'd0), carry: carry_in};
			end
			cpu8alu_pkg::OP_RLCA: begin
				res = '{value: {acc[6:0], acc[7]}, do_write: 1'b1, zero: 1'b0,
					sub: 1'b0, half: 1'b0, carry: acc[7]};
			end
			cpu8alu_pkg::OP_RRCA: begin
				res = '{value: {acc[0], acc[7:1]}, do_write: 1'b1, zero: 1'b0,
					sub: 1'b0, half: 1'b0, carry: acc[0]};
			end
			cpu8alu_pkg::OP_RLA: begin
				res = '{value: {acc[6:0], carry_in}, do_write: 1'b1, zero: 1'b0,
					sub: 1'b0, half: 1'b0, carry: acc[7]};
			end
			cpu8alu_pkg::OP_RRA: begin
				res = '{value: {carry_in, acc[7:1]}, do_write: 1'b1, zero: 1'b0,
					sub: 1'b0, half: 1'b0, carry: acc[0]};
			end
			cpu8alu_pkg::OP_DAA: begin
				r   = sub_in ? (acc - adj) : (acc + adj);
				res = '{value: r, do_write: 1'b1, zero: (r == '0), sub: sub_in,
					half: 1'b0, carry: daa_c};
			end
			cpu8alu_pkg::OP_CPL: begin
				res = '{value: ~acc, do_write: 1'b1, zero: zero_in, sub: 1'b1,
					half: 1'b1, carry: carry_in};
			end
			cpu8alu_pkg::OP_SCF: begin
				res = '{value: acc, do_write: 1'b0, zero: zero_in, sub: 1'b0,
					half: 1'b0, carry: 1'b1};
			end
			cpu8alu_pkg::OP_CCF: begin
				res = '{value: acc, do_write: 1'b0, zero: zero_in, sub: 1'b0,
					half: 1'b0, carry: ~carry_in};
			end
			default: begin
				res = '{value: acc, do_write: 1'b0, zero: zero_in, sub: sub_in,
					half: half_in, carry: carry_in};
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cpu_8bit_alu_with_flags_top.sv =====
// -----------------------------------------------------------------------------
// cpu_8bit_alu_with_flags_top
// 8-bit accumulator ALU with zero, subtract, half-carry and carry flags.
//
// Channel   Direction  Handshake        Fields
// command   in         start, busy      kind, acc, operand, flag inputs
// result    out        done             value, do_write, flag outputs
//
// An item is registered at the edge where start is high and busy is low.
// Its result is computed from the stage-1 registers and driven with done from the stage-2 registers.
// One item is taken every cycle; busy stays low because nothing can stall.
// Reset clears only the valid bits of both stages.
// -----------------------------------------------------------------------------
`default_nettype none

`include "cpu_8bit_alu_with_flags_top_assert.svh"

module cpu_8bit_alu_with_flags_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [cpu8alu_pkg::KindW-1:0] kind,
	input  wire logic [cpu8alu_pkg::DataW-1:0] acc,
	input  wire logic [cpu8alu_pkg::DataW-1:0] operand,
	input  wire logic                          zero_in,
	input  wire logic                          sub_in,
	input  wire logic                          half_in,
	input  wire logic                          carry_in,
	output logic                               done,
	output logic [cpu8alu_pkg::DataW-1:0]      value,
	output logic                               do_write,
	output logic                               zero_out,
	output logic                               sub_out,
	output logic                               half_out,
	output logic                               carry_out
);

	logic                          valid_s1;
	logic [cpu8alu_pkg::KindW-1:0] kind_s1;
	logic [cpu8alu_pkg::DataW-1:0] acc_s1;
	logic [cpu8alu_pkg::DataW-1:0] operand_s1;
	logic                          zero_s1;
	logic                          sub_s1;
	logic                          half_s1;
	logic                          carry_s1;
	cpu8alu_pkg::alu_res_t         res;
	logic                          valid_s2;
	cpu8alu_pkg::alu_res_t         res_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1    <= kind;
		acc_s1     <= acc;
		operand_s1 <= operand;
		zero_s1    <= zero_in;
		sub_s1     <= sub_in;
		half_s1    <= half_in;
		carry_s1   <= carry_in;
		res_s2     <= res;
	end

	cpu8alu_core u_core (
		.kind     (kind_s1),
		.acc      (acc_s1),
		.operand  (operand_s1),
		.zero_in  (zero_s1),
		.sub_in   (sub_s1),
		.half_in  (half_s1),
		.carry_in (carry_s1),
		.res      (res)
	);

	assign done      = valid_s2;
	assign value     = res_s2.value;
	assign do_write  = res_s2.do_write;
	assign zero_out  = res_s2.zero;
	assign sub_out   = res_s2.sub;
	assign half_out  = res_s2.half;
	assign carry_out = res_s2.carry;

	`CPU8ALU_ASSERT_NXT(a_valid_moves, clk, arst_n, valid_s1, done)
	`CPU8ALU_ASSERT_NXT(a_no_extra_done, clk, arst_n, !valid_s1, !done)
	`CPU8ALU_ASSERT_IMP(a_nowrite_keeps_acc, clk, arst_n, done && !do_write, value == $past(acc_s1))
	`CPU8ALU_ASSERT_IMP(a_busy_low, clk, arst_n, start, !busy)

endmodule

`default_nettype wire
